[hdl/pfsa_pkg.sv]
`timescale 1ns / 1ps
package pfsa_pkg;

	// default sizes
	localparam int unsigned STACK_DEPTH_DEF = 8192;
	localparam int unsigned PAGE_BYTES_DEF  = 4096;

	// field widths
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned TOTAL_W  = 21;
	localparam int unsigned CFG_IDX_W = 1;

	// stream widths, padded to whole bytes
	localparam int unsigned S_TDATA_W = 96;
	localparam int unsigned M_TDATA_W = 56;

	// region rules
	localparam logic [DATA_W-1:0]  USABLE_TYPE = 32'd1;
	localparam logic [DATA_W-1:0]  REGION_BASE = 32'h0010_0000;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 21'd1048576;
	localparam logic [DATA_W-1:0]  MAX_ADDR_RST = 32'h2000_0000;

	// wide page arithmetic, enough headroom past the 32-bit space
	localparam int unsigned PAGE_W = 34;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC  = 2'd0,
		KIND_FREE   = 2'd1,
		KIND_REGION = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_SIZE = 1'd0,
		REG_MAX_PHYS    = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_REGION
	} state_t;

endpackage

[hdl/page_frame_stack_allocator_top.sv]
`timescale 1ns / 1ps
// Free page stack allocator: a LIFO of free page addresses held in one
// synchronous memory of STACK_DEPTH words.
// Input request (s_*): kind in s_tuser, address/length/region_type in s_tdata.
// Result (m_*): one result per request, held in an output register until
// m_tready takes it; a new request is accepted while the result drains.
// Config (cfg_*): always ready; kernel_size (index 0), max_phys_addr (index 1),
// to be written only while the block is idle; the block itself does not enforce it.
// Timing, set by the single memory port and a registered read:
//   free, no-op, unusable region and empty-stack allocate: result in the
//   next cycle, one per cycle while m_tready is high; allocate: stack read in
//   ST_POP, then the result is registered, input held off meanwhile; region: one
//   page pushed per cycle, result after the last push; input is held off meanwhile
// Reset clears the stack pointer, page count and registers to their defaults;
// the memory is not cleared, since only pushed entries are ever popped.
// If the receiver stalls, the result waits in the output register and no
// further request is taken until it can be replaced.
module page_frame_stack_allocator_top #(
	parameter int unsigned STACK_DEPTH = pfsa_pkg::STACK_DEPTH_DEF,
	parameter int unsigned PAGE_BYTES  = pfsa_pkg::PAGE_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pfsa_pkg::S_TDATA_W-1:0]  s_tdata,   // address, length, region_type
	input  logic [pfsa_pkg::KIND_W-1:0]     s_tuser,   // kind
	// result
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pfsa_pkg::M_TDATA_W-1:0]  m_tdata,   // page_address, status, total_pages, pad
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pfsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfsa_pkg::DATA_W-1:0]     cfg_data
);
	import pfsa_pkg::*;

	localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
	localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(STACK_DEPTH);
	localparam logic [PAGE_W-1:0] STEP_C  = PAGE_W'(PAGE_BYTES);

	// stack memory
	logic [DATA_W-1:0] mem [STACK_DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// control state
	state_t            state_q, state_n;
	logic [CNT_W-1:0]  top_q, top_n;
	logic [TOTAL_W-1:0] total_q, total_n;
	logic [DATA_W-1:0] ksize_q;
	logic [DATA_W-1:0] maxaddr_q;
	logic [PAGE_W-1:0] page_q;
	logic [PAGE_W-1:0] end_q;

	// result register
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_addr_q;
	status_t             out_status_q;
	logic [TOTAL_W-1:0]  out_total_q;

	// request fields
	kind_t             kind;
	logic [DATA_W-1:0] in_addr;
	logic [DATA_W-1:0] in_len;
	logic [DATA_W-1:0] in_type;

	logic              acc;
	logic              usable;
	logic              empty;
	logic              full;
	logic              region_go;

	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              page_step;
	logic              out_load;
	logic [DATA_W-1:0] out_addr_n;
	status_t           out_status_n;
	logic [CNT_W-1:0]  top_dec;

	assign kind    = kind_t'(s_tuser);
	assign in_addr = s_tdata[DATA_W-1:0];
	assign in_len  = s_tdata[2*DATA_W-1:DATA_W];
	assign in_type = s_tdata[3*DATA_W-1:2*DATA_W];

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {1'b0, out_total_q, out_status_q, out_addr_q};

	assign s_tready  = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign acc       = s_tvalid && s_tready;
	assign usable    = (in_type == USABLE_TYPE) && (in_addr == REGION_BASE);
	assign empty     = (top_q == '0);
	assign full      = (top_q == DEPTH_C);
	assign region_go = (page_q < end_q) && (page_q <= {2'b00, maxaddr_q});
	assign top_dec   = top_q - CNT_W'(1);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && kind == KIND_ALLOC && !empty) begin
					state_n = ST_POP;
				end else if (acc && kind == KIND_REGION && usable) begin
					state_n = ST_REGION;
				end
			end
			ST_POP: begin
				state_n = ST_IDLE;
			end
			ST_REGION: begin
				if (!region_go || full) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// datapath control and result
	always_comb begin
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_waddr    = top_q[ADDR_W-1:0];
		mem_raddr    = top_dec[ADDR_W-1:0];
		mem_wdata    = in_addr;
		page_step    = 1'b0;
		out_load     = 1'b0;
		out_addr_n   = '0;
		out_status_n = STAT_OK;
		top_n        = top_q;
		total_n      = total_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (kind)
						KIND_ALLOC: begin
							if (empty) begin
								out_load     = 1'b1;
								out_status_n = STAT_EMPTY;
							end else begin
								mem_re = 1'b1;
								top_n  = top_dec;
							end
						end
						KIND_FREE: begin
							out_load = 1'b1;
							if (full) begin
								out_status_n = STAT_FULL;
							end else begin
								mem_we = 1'b1;
								top_n  = top_q + CNT_W'(1);
							end
						end
						KIND_REGION: begin
							out_load = !usable;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			ST_POP: begin
				out_load   = 1'b1;
				out_addr_n = rd_data_q;
			end
			ST_REGION: begin
				if (!region_go) begin
					out_load = 1'b1;
				end else if (full) begin
					out_load     = 1'b1;
					out_status_n = STAT_FULL;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = page_q[DATA_W-1:0];
					page_step = 1'b1;
					top_n     = top_q + CNT_W'(1);
					if (total_q < TOTAL_MAX) begin
						total_n = total_q + TOTAL_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// stack memory port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// region walk registers
	always_ff @(posedge clk) begin
		if (acc) begin
			page_q <= PAGE_W'(in_addr) + PAGE_W'(ksize_q);
			end_q  <= PAGE_W'(in_addr) + PAGE_W'(in_len);
		end else if (page_step) begin
			page_q <= page_q + STEP_C;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_addr_q   <= out_addr_n;
			out_status_q <= out_status_n;
			out_total_q  <= total_n;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			top_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			top_q   <= top_n;
			total_q <= total_n;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksize_q   <= '0;
			maxaddr_q <= MAX_ADDR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KERNEL_SIZE: ksize_q   <= cfg_data;
				REG_MAX_PHYS:    maxaddr_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

[tb/page_stack_checker.sv]
`timescale 1ns / 1ps
module page_stack_checker
	import pfsa_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // address, length, region_type
	input  logic [KIND_W-1:0]    s_tuser,   // kind
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,   // page_address, status, total_pages, pad
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	output int                   fail_count,
	output int                   pending_count
);

	localparam int unsigned FILL_IDX_W = $clog2(STACK_DEPTH);

	typedef struct packed {
		logic [DATA_W-1:0]  page_address;
		status_t            status;
		logic [TOTAL_W-1:0] total_pages;
	} frame_result_t;

	// mirror of the free page stack and the block's settings
	logic [DATA_W-1:0]  free_pages [STACK_DEPTH];
	int unsigned        stack_fill   = 0;
	logic [TOTAL_W-1:0] pages_added  = '0;
	logic [DATA_W-1:0]  kernel_skip  = '0;
	logic [DATA_W-1:0]  addr_ceiling = MAX_ADDR_RST;
	frame_result_t      expected_results [$];

	initial begin
		fail_count = 0;
		pending_count = 0;
	end

	// apply one request to the mirror and return the result it should give
	function automatic frame_result_t predict_frame_result(kind_t kind,
			logic [DATA_W-1:0] addr, logic [DATA_W-1:0] len, logic [DATA_W-1:0] rtype);
		frame_result_t res;
		logic [PAGE_W-1:0] page;
		logic [PAGE_W-1:0] region_end;
		res.page_address = '0;
		res.status = STAT_OK;
		case (kind)
			KIND_ALLOC: begin
				if (stack_fill == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					stack_fill--;
					res.page_address = free_pages[stack_fill[FILL_IDX_W-1:0]];
				end
			end
			KIND_FREE: begin
				if (stack_fill >= STACK_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					free_pages[stack_fill[FILL_IDX_W-1:0]] = addr;
					stack_fill++;
				end
			end
			KIND_REGION: begin
				if (rtype == USABLE_TYPE && addr == REGION_BASE) begin
					// wide arithmetic so the region never wraps the 32-bit space
					page = PAGE_W'(addr) + PAGE_W'(kernel_skip);
					region_end = PAGE_W'(addr) + PAGE_W'(len);
					while (page < region_end && page <= PAGE_W'(addr_ceiling)) begin
						if (stack_fill >= STACK_DEPTH) begin
							res.status = STAT_FULL;
							break;
						end
						free_pages[stack_fill[FILL_IDX_W-1:0]] = page[DATA_W-1:0];
						stack_fill++;
						if (pages_added < TOTAL_MAX)
							pages_added++;
						page = page + PAGE_W'(PAGE_BYTES);
					end
				end
			end
			default: begin
			end
		endcase
		res.total_pages = pages_added;
		return res;
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		frame_result_t seen;
		frame_result_t want;
		if (!arst_n) begin
			stack_fill = 0;
			pages_added = '0;
			kernel_skip = '0;
			addr_ceiling = MAX_ADDR_RST;
			expected_results.delete();
			pending_count <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_KERNEL_SIZE: kernel_skip = cfg_data;
					REG_MAX_PHYS:    addr_ceiling = cfg_data;
					default: begin
					end
				endcase
			end
			// results against the oldest prediction
			if (m_tvalid && m_tready) begin
				seen.page_address = m_tdata[0 +: DATA_W];
				seen.status = status_t'(m_tdata[DATA_W +: STATUS_W]);
				seen.total_pages = m_tdata[DATA_W+STATUS_W +: TOTAL_W];
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: result with none expected: expected nothing, actual %h",
						$time, m_tdata);
				end else begin
					want = expected_results.pop_front();
					check_field("page_address", want.page_address, seen.page_address);
					check_field("status", DATA_W'(want.status), DATA_W'(seen.status));
					check_field("total_pages", DATA_W'(want.total_pages),
						DATA_W'(seen.total_pages));
				end
			end
			// accepted requests
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_frame_result(kind_t'(s_tuser),
					s_tdata[0 +: DATA_W], s_tdata[DATA_W +: DATA_W],
					s_tdata[2*DATA_W +: DATA_W]));
			pending_count <= expected_results.size();
		end
	end

endmodule

[tb/tb_page_frame_stack_allocator_top.sv]
`timescale 1ns / 1ps
module tb_page_frame_stack_allocator_top;
	import pfsa_pkg::*;

	localparam int HOLD_CYCLES = 300;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic [KIND_W-1:0]    s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data  = '0;

	int fail_count;
	int pending_count;
	bit calm      = 1'b0;
	int hold_asks = 0;

	always #5 clk = ~clk;

	page_frame_stack_allocator_top #(
		.STACK_DEPTH(STACK_DEPTH_DEF),
		.PAGE_BYTES (PAGE_BYTES_DEF)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	page_stack_checker #(
		.STACK_DEPTH(STACK_DEPTH_DEF),
		.PAGE_BYTES (PAGE_BYTES_DEF)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	// result side: random back-pressure, calm stretches and long hold-offs
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 28);
			end
		end
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// offer one request, with random idle cycles ahead of it
	task automatic send_req(input kind_t kind, input logic [DATA_W-1:0] addr,
			input logic [DATA_W-1:0] len, input logic [DATA_W-1:0] rtype);
		while (!calm && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {rtype, len, addr};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [DATA_W-1:0] kernel_bytes,
			input logic [DATA_W-1:0] ceiling);
		write_reg(REG_KERNEL_SIZE, kernel_bytes);
		write_reg(REG_MAX_PHYS, ceiling);
	endtask

	// mostly alloc/free traffic and usable-ram regions, some junk entries
	task automatic rand_req(input bit wide_len);
		int pick;
		logic [DATA_W-1:0] len;
		pick = $urandom_range(99);
		len = wide_len ? $urandom : $urandom_range(32'h40000);
		if (pick < 34)
			send_req(KIND_ALLOC, $urandom, $urandom, $urandom);
		else if (pick < 68)
			send_req(KIND_FREE, $urandom, $urandom, $urandom);
		else if (pick < 88)
			send_req(KIND_REGION, REGION_BASE, len, USABLE_TYPE);
		else if (pick < 91)
			send_req(KIND_REGION, $urandom, len, USABLE_TYPE);
		else if (pick < 95)
			send_req(KIND_REGION, REGION_BASE, len, $urandom);
		else
			send_req(KIND_NOP, $urandom, $urandom, $urandom);
	endtask

	task automatic run_random(input int count, input bit wide_len, input int hold_at,
			input int calm_from, input int calm_to);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_asks <= hold_asks + 1;
			if (i == calm_from)
				calm <= 1'b1;
			if (i == calm_to)
				calm <= 1'b0;
			rand_req(wide_len);
		end
		wait_all_results();
	endtask

	// stimulus and verdict
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack, lifo order, extreme addresses
		send_req(KIND_ALLOC, '0, '0, '0);
		send_req(KIND_FREE, '1, '0, '0);
		send_req(KIND_FREE, '0, '1, '1);
		send_req(KIND_FREE, 32'h5A5A_5A5A, '0, '0);
		send_req(KIND_ALLOC, '0, '0, '0);
		send_req(KIND_ALLOC, '0, '0, '0);
		send_req(KIND_ALLOC, '0, '0, '0);
		send_req(KIND_ALLOC, '1, '1, '1);
		send_req(KIND_NOP, '1, '1, '1);
		// regions at reset settings, usable and not
		send_req(KIND_REGION, REGION_BASE, 32'h4000, USABLE_TYPE);
		send_req(KIND_REGION, REGION_BASE, 32'h4000, 32'd2);
		send_req(KIND_REGION, REGION_BASE + 32'h1000, 32'h4000, USABLE_TYPE);
		send_req(KIND_REGION, REGION_BASE, 32'h4000, '1);
		send_req(KIND_REGION, REGION_BASE, 32'h4000, '0);
		send_req(KIND_REGION, REGION_BASE, '0, USABLE_TYPE);
		send_req(KIND_REGION, REGION_BASE, 32'h1, USABLE_TYPE);
		send_req(KIND_ALLOC, '0, '0, '0);
		send_req(KIND_ALLOC, '0, '0, '0);
		wait_all_results();

		// kernel skip with a ceiling that cuts the region short
		set_limits(32'h2000, 32'h0010_4000);
		send_req(KIND_REGION, REGION_BASE, 32'h10000, USABLE_TYPE);
		wait_all_results();
		// start past the end, no wrap
		set_limits('1, '1);
		send_req(KIND_REGION, REGION_BASE, '1, USABLE_TYPE);
		wait_all_results();
		// zero ceiling blocks every page
		set_limits('0, '0);
		send_req(KIND_REGION, REGION_BASE, 32'h10000, USABLE_TYPE);
		wait_all_results();

		// random phases under different settings
		set_limits(32'h3000, MAX_ADDR_RST);
		run_random(210, 1'b0, 60, -1, -1);
		set_limits($urandom_range(32'h8000), 32'h0018_0000);
		run_random(210, 1'b1, -1, 60, 160);
		set_limits('0, REGION_BASE + $urandom_range(32'h40000));
		run_random(210, 1'b0, 150, -1, -1);

		// fill the stack, then push onto a full stack
		set_limits('0, '1);
		send_req(KIND_REGION, REGION_BASE, '1, USABLE_TYPE);
		send_req(KIND_FREE, 32'h1234_5678, '0, '0);
		send_req(KIND_REGION, REGION_BASE, '1, USABLE_TYPE);
		send_req(KIND_ALLOC, '0, '0, '0);
		send_req(KIND_FREE, 32'h8765_4321, '0, '0);
		send_req(KIND_FREE, 32'h1357_9BDF, '0, '0);
		wait_all_results();
		repeat (20) @(posedge clk);

		if (fail_count == 0 && pending_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
